### rtl/core/irpd_pkg.sv
package irpd_pkg;

	// Field widths
	localparam int unsigned SampleW = 10;
	localparam int unsigned LevelW  = 10;
	localparam int unsigned DiffW   = 11;
	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgW    = 10;

	// Default ring depths
	localparam int unsigned DefSampleDepth = 16;
	localparam int unsigned DefVoteDepth   = 8;

	// Register reset values
	localparam logic [LevelW-1:0] ThresholdReset  = 10'd64;
	localparam logic [LevelW-1:0] HysteresisReset = 10'd16;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_THRESHOLD  = 1'b0,
		CFG_HYSTERESIS = 1'b1
	} cfg_reg_t;

	// Per-stage control: load takes a new item in, fire moves the held item on
	typedef struct packed {
		logic load;
		logic fire;
	} stage_ctrl_t;

endpackage

### rtl/core/irpd_sample_stage.sv
module irpd_sample_stage #(
	parameter int unsigned SAMPLE_DEPTH = irpd_pkg::DefSampleDepth,
	localparam int unsigned SumW = irpd_pkg::SampleW + $clog2(SAMPLE_DEPTH)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  irpd_pkg::stage_ctrl_t           ctrl,
	input  logic [irpd_pkg::SampleW-1:0]    ambient_sample,
	input  logic [irpd_pkg::SampleW-1:0]    lit_sample,
	output logic [SumW-1:0]                 sum_ambient,
	output logic [SumW-1:0]                 sum_lit
);

	localparam int unsigned IdxW  = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;
	localparam int unsigned WordW = 2 * irpd_pkg::SampleW;

	// Both rings share one memory word: {ambient, lit}
	logic [WordW-1:0] ring_mem [SAMPLE_DEPTH];
	logic [WordW-1:0] rdata_q;

	logic [IdxW-1:0] idx_q;
	logic            wrap_q;

	logic [irpd_pkg::SampleW-1:0] ambient_s1;
	logic [irpd_pkg::SampleW-1:0] lit_s1;
	logic [IdxW-1:0]              idx_s1;
	logic                         old_ok_s1;
	logic                         fwd_s1;
	logic [WordW-1:0]             fwd_data_s1;

	logic [SumW-1:0]              sum_ambient_q;
	logic [SumW-1:0]              sum_lit_q;

	logic [WordW-1:0]             old_word;
	logic [IdxW-1:0]              idx_next;
	logic [SumW:0]                sum_ambient_d;
	logic [SumW:0]                sum_lit_d;

	assign idx_next = (idx_q == IdxW'(SAMPLE_DEPTH - 1)) ? '0 : idx_q + 1'b1;

	// Ring memory: write back in s1, read at accept
	always_ff @(posedge clk) begin
		if (ctrl.fire)
			ring_mem[idx_s1] <= {ambient_s1, lit_s1};
		if (ctrl.load)
			rdata_q <= ring_mem[idx_q];
	end

	// Item capture into s1
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			ambient_s1  <= ambient_sample;
			lit_s1      <= lit_sample;
			idx_s1      <= idx_q;
			fwd_data_s1 <= {ambient_s1, lit_s1};
		end
	end

	// Write index, fill flag and forwarding select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			wrap_q    <= 1'b0;
			old_ok_s1 <= 1'b0;
			fwd_s1    <= 1'b0;
		end else if (ctrl.load) begin
			idx_q     <= idx_next;
			old_ok_s1 <= wrap_q;
			fwd_s1    <= ctrl.fire && (idx_s1 == idx_q);
			if (idx_q == IdxW'(SAMPLE_DEPTH - 1))
				wrap_q <= 1'b1;
		end
	end

	// Entry being replaced; unwritten entries count as zero
	always_comb begin
		if (fwd_s1)
			old_word = fwd_data_s1;
		else if (old_ok_s1)
			old_word = rdata_q;
		else
			old_word = '0;
	end

	assign sum_ambient_d = {1'b0, sum_ambient_q} + (SumW + 1)'(ambient_s1)
		- (SumW + 1)'(old_word[WordW-1 -: irpd_pkg::SampleW]);
	assign sum_lit_d = {1'b0, sum_lit_q} + (SumW + 1)'(lit_s1)
		- (SumW + 1)'(old_word[irpd_pkg::SampleW-1:0]);

	// Running sums; they also serve as the s2 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_ambient_q <= '0;
			sum_lit_q     <= '0;
		end else if (ctrl.fire) begin
			sum_ambient_q <= sum_ambient_d[SumW-1:0];
			sum_lit_q     <= sum_lit_d[SumW-1:0];
		end
	end

	assign sum_ambient = sum_ambient_q;
	assign sum_lit     = sum_lit_q;

endmodule

### rtl/core/irpd_mean_stage.sv
module irpd_mean_stage #(
	parameter int unsigned SAMPLE_DEPTH = irpd_pkg::DefSampleDepth,
	localparam int unsigned SumW = irpd_pkg::SampleW + $clog2(SAMPLE_DEPTH)
) (
	input  logic                          clk,
	input  logic                          load,
	input  logic [SumW-1:0]               sum_ambient,
	input  logic [SumW-1:0]               sum_lit,
	output logic [irpd_pkg::SampleW-1:0]  mean_ambient_s3,
	output logic [irpd_pkg::SampleW-1:0]  mean_lit_s3
);

	// sum / depth as multiply by ceil(2^Shift / depth), exact for all sums
	localparam int unsigned Shift = SumW + $clog2(SAMPLE_DEPTH);
	localparam int unsigned RecW  = SumW + 1;
	localparam int unsigned ProdW = SumW + RecW;
	localparam logic [RecW-1:0] Recip =
		RecW'(((64'd1 << Shift) + 64'(SAMPLE_DEPTH) - 64'd1) / 64'(SAMPLE_DEPTH));

	logic [ProdW-1:0] prod_ambient;
	logic [ProdW-1:0] prod_lit;

	assign prod_ambient = ProdW'(sum_ambient) * ProdW'(Recip);
	assign prod_lit     = ProdW'(sum_lit) * ProdW'(Recip);

	// s3 register: truncated means
	always_ff @(posedge clk) begin
		if (load) begin
			mean_ambient_s3 <= prod_ambient[Shift +: irpd_pkg::SampleW];
			mean_lit_s3     <= prod_lit[Shift +: irpd_pkg::SampleW];
		end
	end

endmodule

### rtl/core/irpd_vote_stage.sv
module irpd_vote_stage #(
	parameter int unsigned VOTE_DEPTH = irpd_pkg::DefVoteDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          fire,
	input  logic [irpd_pkg::LevelW-1:0]   threshold,
	input  logic [irpd_pkg::LevelW-1:0]   hysteresis,
	input  logic [irpd_pkg::SampleW-1:0]  mean_ambient,
	input  logic [irpd_pkg::SampleW-1:0]  mean_lit,
	output logic                          present,
	output logic [irpd_pkg::DiffW-1:0]    difference
);

	localparam int unsigned IdxW = (VOTE_DEPTH > 1) ? $clog2(VOTE_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(VOTE_DEPTH + 1);
	localparam int unsigned CmpW = irpd_pkg::DiffW + 1;

	logic vote_mem [VOTE_DEPTH];
	logic vrd_q;
	logic vfwd_q;
	logic vfwd_bit_q;

	logic [IdxW-1:0] vidx_q;
	logic [IdxW-1:0] vidx_d;
	logic            vwrap_q;
	logic [CntW-1:0] vcount_q;
	logic [CntW-1:0] vcount_d;
	logic            present_q;

	logic signed [CmpW-1:0] diff;
	logic signed [CmpW-1:0] low_mark;
	logic signed [CmpW-1:0] thr_s;
	logic                   push_absent;
	logic                   push_present;
	logic                   do_push;
	logic                   old_vote;
	logic                   present_d;

	// Difference of means and hysteresis decision
	assign diff     = signed'(CmpW'(mean_ambient)) - signed'(CmpW'(mean_lit));
	assign thr_s    = signed'(CmpW'(threshold));
	assign low_mark = thr_s - signed'(CmpW'(hysteresis));

	assign push_absent  = present_q && (diff <= low_mark);
	assign push_present = !present_q && (diff >= thr_s);
	assign do_push      = fire && (push_absent || push_present);

	assign vidx_d = !do_push ? vidx_q
		: (vidx_q == IdxW'(VOTE_DEPTH - 1)) ? '0 : vidx_q + 1'b1;

	// Vote memory: read ahead at the next write slot every cycle
	always_ff @(posedge clk) begin
		if (do_push)
			vote_mem[vidx_q] <= push_present;
		vrd_q <= vote_mem[vidx_d];
	end

	// Vote leaving the ring; unwritten entries count as zero
	always_comb begin
		if (vfwd_q)
			old_vote = vfwd_bit_q;
		else if (vwrap_q)
			old_vote = vrd_q;
		else
			old_vote = 1'b0;
	end

	assign vcount_d  = do_push ? vcount_q + CntW'(push_present) - CntW'(old_vote) : vcount_q;
	assign present_d = (vcount_d == CntW'(VOTE_DEPTH));

	// Vote ring control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vidx_q     <= '0;
			vwrap_q    <= 1'b0;
			vcount_q   <= '0;
			present_q  <= 1'b0;
			vfwd_q     <= 1'b0;
			vfwd_bit_q <= 1'b0;
		end else begin
			vfwd_q     <= do_push && (vidx_d == vidx_q);
			vfwd_bit_q <= push_present;
			if (do_push) begin
				vidx_q   <= vidx_d;
				vcount_q <= vcount_d;
				if (vidx_q == IdxW'(VOTE_DEPTH - 1))
					vwrap_q <= 1'b1;
			end
			if (fire)
				present_q <= present_d;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			present    <= present_d;
			difference <= diff[irpd_pkg::DiffW-1:0];
		end
	end

endmodule

### rtl/core/ir_presence_detector_top.sv
// IR presence detector.
// Sample channel: one item is an ambient (emitter off) and a lit (emitter on)
// 10-bit reading, taken when sample_valid is high and sample_stall is low.
// Result channel: present and a signed 11-bit difference of the ring means,
// offered with result_valid; the receiver holds it with result_stall.
// Every sample item gives exactly one result item, in order.
// A result is offered from the output register after its item has passed s1, s2 and s3.
// Throughput: one item per cycle while the receiver does not stall. The pace is set
// by the ring memory read-modify-write (read at accept, write back when the item
// leaves s1, with forwarding) and the running-sum and vote-count updates.
// A stalled receiver fills the four pipeline slots, after which
// sample_stall rises; nothing is dropped and the held result stays put.
// Reset clears indexes, fill flags, sums and the present flag (rings are not
// cleared; unwritten entries read as zero) and loads threshold 64 and
// hysteresis 16. The user writes registers through cfg_we/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
module ir_presence_detector_top #(
	parameter int unsigned SAMPLE_DEPTH = irpd_pkg::DefSampleDepth,
	parameter int unsigned VOTE_DEPTH   = irpd_pkg::DefVoteDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [irpd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [irpd_pkg::CfgW-1:0]     cfg_data,
	input  logic                          sample_valid,
	output logic                          sample_stall,
	input  logic [irpd_pkg::SampleW-1:0]  ambient_sample,
	input  logic [irpd_pkg::SampleW-1:0]  lit_sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          present,
	output logic [irpd_pkg::DiffW-1:0]    difference
);

	localparam int unsigned SumW = irpd_pkg::SampleW + $clog2(SAMPLE_DEPTH);

	logic [irpd_pkg::LevelW-1:0] threshold_q;
	logic [irpd_pkg::LevelW-1:0] hysteresis_q;

	logic v1_q, v2_q, v3_q, ov_q;
	logic out_free, en1, en2, en3, fire1, fire2, fire3, in_acc;

	irpd_pkg::stage_ctrl_t sample_ctrl;

	logic [SumW-1:0]              sum_ambient;
	logic [SumW-1:0]              sum_lit;
	logic [irpd_pkg::SampleW-1:0] mean_ambient_s3;
	logic [irpd_pkg::SampleW-1:0] mean_lit_s3;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q  <= irpd_pkg::ThresholdReset;
			hysteresis_q <= irpd_pkg::HysteresisReset;
		end else if (cfg_we) begin
			case (irpd_pkg::cfg_reg_t'(cfg_index))
				irpd_pkg::CFG_THRESHOLD:  threshold_q  <= cfg_data[irpd_pkg::LevelW-1:0];
				irpd_pkg::CFG_HYSTERESIS: hysteresis_q <= cfg_data[irpd_pkg::LevelW-1:0];
				default: ;
			endcase
		end
	end

	// Pipeline flow control: each slot loads when empty or moving on
	assign out_free = !ov_q || !result_stall;
	assign fire3    = v3_q && out_free;
	assign en3      = !v3_q || out_free;
	assign fire2    = v2_q && en3;
	assign en2      = !v2_q || en3;
	assign fire1    = v1_q && en2;
	assign en1      = !v1_q || en2;
	assign in_acc   = sample_valid && en1;

	assign sample_stall = !en1;
	assign result_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (en1)
				v1_q <= in_acc;
			if (en2)
				v2_q <= fire1;
			if (en3)
				v3_q <= fire2;
			if (out_free)
				ov_q <= fire3;
		end
	end

	assign sample_ctrl.load = in_acc;
	assign sample_ctrl.fire = fire1;

	irpd_sample_stage #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_sample (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (sample_ctrl),
		.ambient_sample (ambient_sample),
		.lit_sample     (lit_sample),
		.sum_ambient    (sum_ambient),
		.sum_lit        (sum_lit)
	);

	irpd_mean_stage #(
		.SAMPLE_DEPTH(SAMPLE_DEPTH)
	) u_mean (
		.clk             (clk),
		.load            (fire2),
		.sum_ambient     (sum_ambient),
		.sum_lit         (sum_lit),
		.mean_ambient_s3 (mean_ambient_s3),
		.mean_lit_s3     (mean_lit_s3)
	);

	irpd_vote_stage #(
		.VOTE_DEPTH(VOTE_DEPTH)
	) u_vote (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire3),
		.threshold    (threshold_q),
		.hysteresis   (hysteresis_q),
		.mean_ambient (mean_ambient_s3),
		.mean_lit     (mean_lit_s3),
		.present      (present),
		.difference   (difference)
	);

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int SAMPLE_N  = irpd_pkg::DefSampleDepth;
	localparam int VOTE_N    = irpd_pkg::DefVoteDepth;
	localparam int SAMPLE_W  = irpd_pkg::SampleW;
	localparam int DIFF_W    = irpd_pkg::DiffW;
	localparam int CFG_W     = irpd_pkg::CfgW;
	localparam int LEVEL_MAX = (1 << SAMPLE_W) - 1;

	typedef struct packed {
		logic              present;
		logic [DIFF_W-1:0] difference;
	} detector_result_t;

	// DUT ports
	logic                         clk            = 1'b0;
	logic                         arst_n         = 1'b0;
	logic                         cfg_we         = 1'b0;
	logic [irpd_pkg::CfgIdxW-1:0] cfg_index      = irpd_pkg::CFG_THRESHOLD;
	logic [CFG_W-1:0]             cfg_data       = '0;
	logic                         sample_valid   = 1'b0;
	logic                         sample_stall;
	logic [SAMPLE_W-1:0]          ambient_sample = '0;
	logic [SAMPLE_W-1:0]          lit_sample     = '0;
	logic                         result_valid;
	logic                         result_stall   = 1'b0;
	logic                         present;
	logic [DIFF_W-1:0]            difference;

	// Predictor state: sample rings, vote ring and level registers
	int unsigned  ambient_hist [SAMPLE_N];
	int unsigned  lit_hist [SAMPLE_N];
	int           sample_slot  = 0;
	bit           vote_hist [VOTE_N];
	int           vote_slot    = 0;
	bit           object_seen  = 1'b0;
	int           threshold_lvl  = int'(irpd_pkg::ThresholdReset);
	int           hysteresis_lvl = int'(irpd_pkg::HysteresisReset);

	detector_result_t expected_results[$];

	// Run bookkeeping
	bit calm = 1'b0;
	int mismatches      = 0;
	int pairs_sent      = 0;
	int results_checked = 0;
	int presence_onsets = 0;
	int level_settings  = 1;

	ir_presence_detector_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.sample_valid   (sample_valid),
		.sample_stall   (sample_stall),
		.ambient_sample (ambient_sample),
		.lit_sample     (lit_sample),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.present        (present),
		.difference     (difference)
	);

	always #5 clk = ~clk;

	initial begin
		foreach (ambient_hist[i]) begin
			ambient_hist[i] = 0;
			lit_hist[i]     = 0;
		end
		foreach (vote_hist[i]) vote_hist[i] = 1'b0;
	end

	// Absorb one sample pair into the rings and work out the flag and difference
	function automatic detector_result_t detect_pair(input logic [SAMPLE_W-1:0] amb,
			input logic [SAMPLE_W-1:0] lit);
		int               amb_sum;
		int               lit_sum;
		int               diff;
		int               ones;
		bit               was_seen;
		detector_result_t res;
		amb_sum  = 0;
		lit_sum  = 0;
		ones     = 0;
		was_seen = object_seen;
		ambient_hist[sample_slot] = 32'(amb);
		lit_hist[sample_slot]     = 32'(lit);
		sample_slot = (sample_slot + 1) % SAMPLE_N;
		for (int i = 0; i < SAMPLE_N; i++) begin
			amb_sum += int'(ambient_hist[i]);
			lit_sum += int'(lit_hist[i]);
		end
		diff = amb_sum / SAMPLE_N - lit_sum / SAMPLE_N;
		// low mark is signed: hysteresis may exceed threshold
		if (object_seen && diff <= threshold_lvl - hysteresis_lvl) begin
			vote_hist[vote_slot] = 1'b0;
			vote_slot = (vote_slot + 1) % VOTE_N;
		end else if (!object_seen && diff >= threshold_lvl) begin
			vote_hist[vote_slot] = 1'b1;
			vote_slot = (vote_slot + 1) % VOTE_N;
		end
		// flag is recomputed even when no vote was cast
		foreach (vote_hist[i]) ones += int'(vote_hist[i]);
		object_seen = ((ones / VOTE_N) & 1) != 0;
		if (object_seen && !was_seen) presence_onsets++;
		res.present    = object_seen;
		res.difference = diff[DIFF_W-1:0];
		return res;
	endfunction

	// Send one item; valid stays high afterwards until the next gap or settle
	task automatic send_pair(input logic [SAMPLE_W-1:0] amb, input logic [SAMPLE_W-1:0] lit);
		if (!calm && $urandom_range(99) < 22) begin
			sample_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 22);
		end
		sample_valid   <= 1'b1;
		ambient_sample <= amb;
		lit_sample     <= lit;
		do @(posedge clk); while (sample_stall);
		expected_results.push_back(detect_pair(amb, lit));
		pairs_sent++;
	endtask

	// Stop sending and wait until the pipeline is empty
	task automatic settle();
		sample_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write both level registers back to back while idle
	task automatic program_levels(input int thr, input int hys);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= irpd_pkg::CFG_THRESHOLD;
		cfg_data  <= thr[CFG_W-1:0];
		@(posedge clk);
		cfg_index <= irpd_pkg::CFG_HYSTERESIS;
		cfg_data  <= hys[CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold_lvl  = thr;
		hysteresis_lvl = hys;
		level_settings++;
	endtask

	// A run of pairs whose ambient-lit gap hovers around center; noise ignores it
	task automatic send_scene(input int count, input int center, input bit noise);
		int off;
		int lit;
		repeat (count) begin
			if (noise) begin
				send_pair(SAMPLE_W'($urandom_range(LEVEL_MAX)),
					SAMPLE_W'($urandom_range(LEVEL_MAX)));
			end else begin
				off = center + int'($urandom_range(16)) - 8;
				if (off > LEVEL_MAX) off = LEVEL_MAX;
				if (off < -LEVEL_MAX) off = -LEVEL_MAX;
				if (off >= 0) lit = int'($urandom_range(LEVEL_MAX - off));
				else lit = int'($urandom_range(LEVEL_MAX, -off));
				send_pair(SAMPLE_W'(lit + off), SAMPLE_W'(lit));
			end
		end
	endtask

	// Scenes alternating object, clear, near-band and noise at the current levels
	task automatic send_scenes(input int pairs);
		int left;
		int n;
		int roll;
		left = pairs;
		while (left > 0) begin
			n = int'($urandom_range(40, 4));
			if (n > left) n = left;
			roll = int'($urandom_range(99));
			if (roll < 20)
				send_scene(n, 0, 1'b1);
			else if (roll < 55)
				send_scene(n, threshold_lvl + int'($urandom_range(60)), 1'b0);
			else if (roll < 85)
				send_scene(n, threshold_lvl - hysteresis_lvl - int'($urandom_range(60)), 1'b0);
			else
				send_scene(n, threshold_lvl - int'($urandom_range(hysteresis_lvl)), 1'b0);
			left -= n;
		end
	endtask

	// Reset levels: full-scale steps raise then drop the flag, then bit patterns
	task automatic check_reset_levels();
		repeat (2) send_pair('0, '0);
		repeat (10) send_pair(SAMPLE_W'(LEVEL_MAX), '0);
		repeat (11) send_pair('0, SAMPLE_W'(LEVEL_MAX));
		send_pair(10'h2AA, 10'h155);
		send_pair(10'h155, 10'h2AA);
	endtask

	// Random scenes across register extremes and hysteresis wider than threshold
	task automatic check_level_settings();
		int thr_list [9] = '{0, 1023, 1023, 0, 10, 200, 64, -1, -1};
		int hys_list [9] = '{0, 1023, 0, 1023, 1023, 50, 16, -1, -1};
		int thr;
		int hys;
		for (int p = 0; p < 9; p++) begin
			thr = (thr_list[p] < 0) ? int'($urandom_range(LEVEL_MAX)) : thr_list[p];
			hys = (hys_list[p] < 0) ? int'($urandom_range(LEVEL_MAX)) : hys_list[p];
			program_levels(thr, hys);
			send_scenes(120);
		end
	endtask

	// No idling on either side: full-rate throughput
	task automatic check_back_to_back();
		program_levels(int'($urandom_range(300)), int'($urandom_range(80)));
		calm = 1'b1;
		send_scenes(200);
		settle();
		calm = 1'b0;
	endtask

	// Receiver stall
	always @(posedge clk) begin
		result_stall <= calm ? 1'b0 : ($urandom_range(99) < 22);
	end

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		detector_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result: present %0d, difference %0d",
					present, $signed(difference));
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (present !== want.present) begin
					$error("present: expected %0d, actual %0d", want.present, present);
					mismatches++;
				end
				if (difference !== want.difference) begin
					$error("difference: expected %0d, actual %0d",
						$signed(want.difference), $signed(difference));
					mismatches++;
				end
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_reset_levels();
		check_level_settings();
		check_back_to_back();
		settle();
		$display("covered %0d sample pairs over %0d level settings, %0d results compared,",
			pairs_sent, level_settings, results_checked);
		$display("  %0d presence onsets predicted, %0d mismatches", presence_onsets, mismatches);
		if (mismatches == 0) begin
			$display("ir_presence_detector_top regression: pass");
		end else begin
			$display("ir_presence_detector_top regression: fail");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2_000_000;
		$display("ir_presence_detector_top regression: fail");
		$finish;
	end

endmodule
